// ===== rtl/b2u8_pkg.sv =====
// Package for the bfloat16 to uint8 converter.
// Holds rounding-mode codes, register indexes and field constants; no dependencies.
package b2u8_pkg;

   localparam logic [2:0] MODE_NEAR_EVEN = 3'd0;
   localparam logic [2:0] MODE_TO_ZERO   = 3'd1;
   localparam logic [2:0] MODE_DOWN      = 3'd2;
   localparam logic [2:0] MODE_UP        = 3'd3;
   localparam logic [2:0] MODE_NEAR_AWAY = 3'd4;
   localparam logic [2:0] MODE_ODD       = 3'd6;

   localparam logic [1:0] CSR_NAN_RESULT = 2'd0;
   localparam logic [1:0] CSR_POS_RESULT = 2'd1;
   localparam logic [1:0] CSR_NEG_RESULT = 2'd2;

   localparam logic [7:0]  EXP_MAX      = 8'hFF;
   localparam logic [7:0]  EXP_TOP      = 8'h86;
   localparam logic [7:0]  EXP_FRAC_LSB = 8'h7A;
   localparam logic [11:0] HALF_ULP     = 12'h800;
   localparam logic [11:0] ROUND_MASK   = 12'hFFF;

   typedef struct packed {
      logic [7:0] nan_result;
      logic [7:0] pos_result;
      logic [7:0] neg_result;
   } sat_regs_type;

   typedef struct packed {
      logic [7:0] int_result;
      logic       invalid_flag;
      logic       inexact_flag;
   } conv_result_type;

endpackage

// ===== rtl/b2u8_csr.sv =====
// Configuration registers holding the saturation values.
// Depends on b2u8_pkg.
module b2u8_csr import b2u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data,
   output sat_regs_type sat_regs
);

   sat_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NAN_RESULT: regs_in.nan_result = csr_data;
            CSR_POS_RESULT: regs_in.pos_result = csr_data;
            CSR_NEG_RESULT: regs_in.neg_result = csr_data;
            default:        regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{nan_result: 8'hFF, pos_result: 8'hFF, neg_result: 8'h00};
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign sat_regs = regs_ff;

endmodule

// ===== rtl/b2u8_core.sv =====
// Combinational conversion of one bfloat16 value with rounding and saturation.
// Depends on b2u8_pkg.
module b2u8_core import b2u8_pkg::*; (
   input  logic [15:0]     bf16_value,
   input  logic [2:0]      mode,
   input  logic            report_inexact,
   input  sat_regs_type    sat_regs,
   output conv_result_type result
);

   logic        neg;
   logic [7:0]  expo;
   logic [6:0]  frac;
   logic [19:0] sig;
   logic [7:0]  sig8;
   logic [3:0]  shamt;
   logic [11:0] inc;
   logic [11:0] rbits;
   logic [20:0] sum;
   logic [8:0]  z;
   logic [7:0]  sat;

   always_comb begin
      neg   = bf16_value[15];
      expo  = bf16_value[14:7];
      frac  = bf16_value[6:0];
      sig8  = {(expo != 8'd0), frac};
      sat   = neg ? sat_regs.neg_result : sat_regs.pos_result;
      shamt = 4'(expo - EXP_FRAC_LSB);
      // Exponents at or below the fraction LSB leave the value below one unit.
      if (expo > EXP_FRAC_LSB) begin
         sig = {12'd0, sig8} << shamt;
      end else begin
         sig = {12'd0, sig8};
      end

      if (mode == MODE_NEAR_EVEN || mode == MODE_NEAR_AWAY) begin
         inc = HALF_ULP;
      end else if ((neg && mode == MODE_DOWN) || (!neg && mode == MODE_UP)) begin
         inc = ROUND_MASK;
      end else begin
         inc = 12'd0;
      end
      rbits = sig[11:0];
      sum   = {1'b0, sig} + {9'd0, inc};
      z     = sum[20:12];
      if (mode == MODE_NEAR_EVEN && rbits == HALF_ULP) z[0] = 1'b0;
      if (mode == MODE_ODD && rbits != 12'd0) z[0] = 1'b1;

      if (expo == EXP_MAX) begin
         result = '{(frac != 7'd0) ? sat_regs.nan_result : sat, 1'b1, 1'b0};
      end else if (expo > EXP_TOP) begin
         result = '{sat, 1'b1, 1'b0};
      end else if (expo == EXP_TOP && !neg) begin
         result = '{sig8, 1'b0, 1'b0};
      end else if (z[8] || (neg && z != 9'd0)) begin
         result = '{sat, 1'b1, 1'b0};
      end else begin
         result = '{z[7:0], 1'b0, report_inexact && (rbits != 12'd0)};
      end
   end

endmodule

// ===== rtl/bf16_to_uint8_convert.sv =====
// Top level of the bfloat16 to uint8 converter.
// Depends on b2u8_pkg, b2u8_csr and b2u8_core.
//
// Usage:
//   The request channel (req_valid, req_stall) carries a bfloat16 value, a
//   rounding mode and the inexact-report enable. The response channel
//   (rsp_valid, rsp_stall) returns the 8-bit integer with invalid and
//   inexact flags, one response per request, in order.
//   Each transaction is captured in an input register, converted by one
//   pass of combinational logic and held in a result register, which
//   drives rsp_valid. One transaction is taken every cycle while req_stall
//   is low; the rate is set by the single register-to-register pass.
//   A stalled response holds its payload; while the result register is
//   full and stalled, the input register still takes one more transaction,
//   and req_stall rises only once both are occupied.
//   The user must write the saturation registers (csr_write, csr_index,
//   csr_data) only while the block is idle; the block does not enforce it.
//   Synchronous reset empties both stages and restores the saturation
//   values: NaN 255, positive overflow 255, negative 0.
module bf16_to_uint8_convert import b2u8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_bf16_value,
   input  logic [2:0]  req_mode,
   input  logic        req_report_inexact,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_int_result,
   output logic        rsp_invalid_flag,
   output logic        rsp_inexact_flag,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   sat_regs_type    sat_regs;
   conv_result_type conv;
   logic            in_vld_ff, in_vld_in;
   logic [15:0]     value_ff, value_in;
   logic [2:0]      mode_ff, mode_in;
   logic            rep_ff, rep_in;
   logic            out_vld_ff, out_vld_in;
   conv_result_type res_ff, res_in;
   logic            out_take, in_take;

   b2u8_csr u_csr (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .sat_regs
   );

   b2u8_core u_core (
      .bf16_value(value_ff), .mode(mode_ff), .report_inexact(rep_ff),
      .sat_regs, .result(conv)
   );

   // The result register loads whenever it is empty or being drained.
   assign out_take  = !out_vld_ff || !rsp_stall;
   assign in_take   = !in_vld_ff || out_take;
   assign req_stall = !in_take;

   always_comb begin
      in_vld_in  = in_vld_ff;
      value_in   = value_ff;
      mode_in    = mode_ff;
      rep_in     = rep_ff;
      out_vld_in = out_vld_ff;
      res_in     = res_ff;
      if (out_take) begin
         out_vld_in = in_vld_ff;
         res_in     = conv;
      end
      if (in_take) begin
         in_vld_in = req_valid;
         value_in  = req_bf16_value;
         mode_in   = req_mode;
         rep_in    = req_report_inexact;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      mode_ff  <= mode_in;
      rep_ff   <= rep_in;
      res_ff   <= res_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_int_result   = res_ff.int_result;
   assign rsp_invalid_flag = res_ff.invalid_flag;
   assign rsp_inexact_flag = res_ff.inexact_flag;

endmodule

// ===== rtl/b2u8_checker.sv =====
// Port-level checker for the bfloat16 to uint8 converter, bound to the top level.
// Depends on bf16_to_uint8_convert's ports only.
module b2u8_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_int_result,
   input logic        rsp_invalid_flag,
   input logic        rsp_inexact_flag
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_int_result)
      && $stable(rsp_invalid_flag) && $stable(rsp_inexact_flag))
      else $error("response changed while stalled");

   // Invalid and inexact are never raised together.
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_invalid_flag && rsp_inexact_flag))
      else $error("invalid and inexact both set");

   // Request stall only when a response is pending and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // After reset nothing is pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // An accepted transaction moves on to rsp_valid once the output is free.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing");

endmodule

bind bf16_to_uint8_convert b2u8_checker u_b2u8_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_int_result, .rsp_invalid_flag, .rsp_inexact_flag
);

// ===== tb/tb.sv =====
// Self-checking testbench for bf16_to_uint8_convert.
// Depends on b2u8_pkg and the block itself; drives directed and random
// transactions and checks each response against a table or a local model.
`timescale 1ns / 100ps

module tb;
   import b2u8_pkg::*;

   // Mode codes with no rounding rule of their own; they truncate.
   localparam logic [2:0] MODE_SPARE_LOW  = 3'd5;
   localparam logic [2:0] MODE_SPARE_HIGH = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_bf16_value = '0;
   logic [2:0]  req_mode = '0;
   logic        req_report_inexact = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_int_result;
   logic        rsp_invalid_flag;
   logic        rsp_inexact_flag;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   bf16_to_uint8_convert dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturation values as the block should currently hold them.
   sat_regs_type    sat;
   conv_result_type pending_results[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              quiet_cycles = 0;
   int              accepted_count = 0;
   int              response_count = 0;

   typedef struct {
      logic [15:0] value;
      logic [2:0]  mode;
      logic        report;
      logic        known;
      logic [7:0]  result;
      logic        invalid;
      logic        inexact;
   } vector_type;

   function automatic conv_result_type convert_bf16(logic [15:0] value, logic [2:0] mode,
                                                    logic report);
      conv_result_type r;
      logic        neg;
      logic [7:0]  expo;
      logic [31:0] sig;
      logic [31:0] inc;
      logic [31:0] rbits;
      logic [31:0] z;
      neg  = value[15];
      expo = value[14:7];
      sig  = {25'd0, value[6:0]};
      r    = '0;
      if (expo == EXP_MAX) begin
         r.int_result   = (value[6:0] != 0) ? sat.nan_result
                                            : (neg ? sat.neg_result : sat.pos_result);
         r.invalid_flag = 1'b1;
         return r;
      end
      if (expo != 0) begin
         sig[7] = 1'b1;
         if (expo > EXP_TOP) begin
            r.int_result   = neg ? sat.neg_result : sat.pos_result;
            r.invalid_flag = 1'b1;
            return r;
         end
         if (expo == EXP_TOP && !neg) begin
            r.int_result = sig[7:0];
            return r;
         end
         if (expo > EXP_FRAC_LSB) sig = sig << (expo - EXP_FRAC_LSB);
      end
      if (mode == MODE_NEAR_EVEN || mode == MODE_NEAR_AWAY) inc = HALF_ULP;
      else if ((neg && mode == MODE_DOWN) || (!neg && mode == MODE_UP)) inc = ROUND_MASK;
      else inc = 0;
      rbits = sig & ROUND_MASK;
      z = (sig + inc) >> 12;
      if (mode == MODE_NEAR_EVEN && rbits == HALF_ULP) z[0] = 1'b0;
      if (mode == MODE_ODD && rbits != 0) z[0] = 1'b1;
      if (z > 255 || (neg && z != 0)) begin
         r.int_result   = neg ? sat.neg_result : sat.pos_result;
         r.invalid_flag = 1'b1;
         return r;
      end
      r.int_result   = z[7:0];
      r.inexact_flag = report && (rbits != 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0d, expected %0d",
               response_count, what, got, want);
      error_count++;
   endtask

   // Response checking and receiver stalls.
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("response %0d arrived with nothing outstanding", response_count);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_int_result !== want.int_result)
                  report_mismatch("int_result", rsp_int_result, want.int_result);
               if (rsp_invalid_flag !== want.invalid_flag)
                  report_mismatch("invalid_flag", rsp_invalid_flag, want.invalid_flag);
               if (rsp_inexact_flag !== want.inexact_flag)
                  report_mismatch("inexact_flag", rsp_inexact_flag, want.inexact_flag);
            end
            response_count++;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog on cycles with no transaction in either direction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Send one transaction, with a random idle gap, and wait for acceptance.
   task automatic send_item(logic [15:0] value, logic [2:0] mode, logic report,
                            logic check_known, conv_result_type known);
      conv_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_bf16_value     <= value;
      req_mode           <= mode;
      req_report_inexact <= report;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = convert_bf16(value, mode, report);
      if (check_known && want != known) begin
         $display("model disagrees with table entry for value %h mode %0d", value, mode);
         error_count++;
      end
      pending_results.push_back(check_known ? known : want);
      accepted_count++;
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [7:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_NAN_RESULT: sat.nan_result = data;
         CSR_POS_RESULT: sat.pos_result = data;
         default:        sat.neg_result = data;
      endcase
   endtask

   // Mostly values in or near the 8-bit range, some anywhere.
   function automatic logic [15:0] random_value();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: v[14:7] = 8'($urandom_range(8'h88, 8'h70));
         5:             v[14:7] = $urandom_range(1) ? EXP_MAX : 8'h00;
         6:             v[15] = 1'b0;
         default: ;
      endcase
      return v;
   endfunction

   vector_type vectors[] = '{
      '{16'h0000, MODE_NEAR_EVEN, 1'b1, 1'b1, 8'd0,   1'b0, 1'b0},
      '{16'h8000, MODE_UP,        1'b1, 1'b1, 8'd0,   1'b0, 1'b0},
      '{16'h7FC0, MODE_NEAR_EVEN, 1'b0, 1'b1, 8'd255, 1'b1, 1'b0},
      '{16'h7F80, MODE_TO_ZERO,   1'b1, 1'b1, 8'd255, 1'b1, 1'b0},
      '{16'hFF80, MODE_DOWN,      1'b1, 1'b1, 8'd0,   1'b1, 1'b0},
      '{16'h437F, MODE_NEAR_EVEN, 1'b1, 1'b1, 8'd255, 1'b0, 1'b0},
      '{16'h4380, MODE_NEAR_EVEN, 1'b1, 1'b1, 8'd255, 1'b1, 1'b0},
      '{16'hC37F, MODE_TO_ZERO,   1'b1, 1'b1, 8'd0,   1'b1, 1'b0},
      '{16'h3F80, MODE_ODD,       1'b1, 1'b1, 8'd1,   1'b0, 1'b0},
      '{16'h0001, MODE_UP,        1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h807F, MODE_DOWN,      1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h807F, MODE_TO_ZERO,   1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_NEAR_EVEN, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h4020, MODE_NEAR_EVEN, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h4020, MODE_NEAR_AWAY, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_TO_ZERO,   1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_DOWN,      1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_UP,        1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h4040, MODE_ODD,       1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_SPARE_LOW, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'h3FC0, MODE_SPARE_HIGH, 1'b1, 1'b0, 8'd0,  1'b0, 1'b0},
      '{16'hBF00, MODE_NEAR_EVEN, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'hBFC0, MODE_UP,        1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{16'hBFC0, MODE_DOWN,      1'b1, 1'b0, 8'd0,   1'b0, 1'b0}
   };

   initial begin
      conv_result_type known;
      logic [7:0] sat_settings[4][3] = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                                         '{8'hA5, 8'h5A, 8'hC3}, '{8'd255, 8'd255, 8'd0}};
      sat.nan_result = 8'd255;
      sat.pos_result = 8'd255;
      sat.neg_result = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         known = '{vectors[i].result, vectors[i].invalid, vectors[i].inexact};
         send_item(vectors[i].value, vectors[i].mode, vectors[i].report, vectors[i].known,
                   known);
      end
      drain_block();

      // Four phases, distinct saturation values, and three idling patterns.
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_NAN_RESULT, sat_settings[phase][0]);
         write_csr(CSR_POS_RESULT, sat_settings[phase][1]);
         write_csr(CSR_NEG_RESULT, sat_settings[phase][2]);
         case (phase)
            0:       begin send_idle_pct = 15; recv_stall_pct = 57; end
            1:       begin send_idle_pct = 57; recv_stall_pct = 15; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (int n = 0; n < 200; n++) begin
            send_item(random_value(), 3'($urandom_range(7)), 1'($urandom_range(1)), 1'b0,
                      known);
            // Hold off once, midway, until the pipeline has emptied.
            if (n == 100) drain_block();
         end
         drain_block();
      end
      recv_stall_pct = 0;

      $display("Sent %0d conversions, %0d responses checked, over four saturation settings",
               accepted_count, response_count);
      $display("and three idling patterns, with all rounding modes and special values.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/b2u8_pkg.sv
rtl/b2u8_csr.sv
rtl/b2u8_core.sv
rtl/bf16_to_uint8_convert.sv
rtl/b2u8_checker.sv
tb/tb.sv
